FILE: sv/jsvp_pkg.sv
package jsvp_pkg;

  localparam int ByteW   = 8;
  localparam int TdataOW = 16;

  typedef enum logic [4:0] {
    PH_LEAD   = 5'd0,
    PH_LIT    = 5'd1,
    PH_STR    = 5'd2,
    PH_ESC    = 5'd3,
    PH_NSIGN  = 5'd4,
    PH_NZERO  = 5'd5,
    PH_NINT   = 5'd6,
    PH_NDOT   = 5'd7,
    PH_NFRAC  = 5'd8,
    PH_NEXP   = 5'd9,
    PH_NESIGN = 5'd10,
    PH_NEDIG  = 5'd11,
    PH_TRAIL  = 5'd12,
    PH_ERR    = 5'd13
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXPECT   = 3'd1,
    ST_INVALID  = 3'd2,
    ST_SINGULAR = 3'd3,
    ST_QUOTE    = 3'd4,
    ST_ESCAPE   = 3'd5,
    ST_CHAR     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    TY_NULL   = 3'd0,
    TY_FALSE  = 3'd1,
    TY_TRUE   = 3'd2,
    TY_NUMBER = 3'd3,
    TY_STRING = 3'd4
  } vtype_e;

  typedef enum logic [1:0] {
    LIT_NULL  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2,
    LIT_NONE  = 2'd3
  } lit_e;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] lit_pos;
    lit_e       lit_choice;
    status_e    held_status;
    vtype_e     held_type;
  } parse_state_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
    vtype_e           vtype;
    status_e          status;
  } result_t;

  localparam parse_state_t StateReset = '{
    phase:       PH_LEAD,
    lit_pos:     3'd0,
    lit_choice:  LIT_NULL,
    held_status: ST_OK,
    held_type:   TY_NULL
  };

  // expected character of a literal word, zero past its end
  function automatic logic [ByteW-1:0] lit_char(lit_e choice, logic [2:0] pos);
    logic [ByteW-1:0] c;
    c = 8'h00;
    case (choice)
      LIT_NULL: begin
        case (pos)
          3'd0:    c = "n";
          3'd1:    c = "u";
          3'd2:    c = "l";
          3'd3:    c = "l";
          default: c = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        case (pos)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          3'd3:    c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          3'd4:    c = "e";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic vtype_e lit_type(lit_e choice);
    vtype_e t;
    case (choice)
      LIT_TRUE:  t = TY_TRUE;
      LIT_FALSE: t = TY_FALSE;
      default:   t = TY_NULL;
    endcase
    return t;
  endfunction

endpackage

FILE: sv/jsvp_step.sv
module jsvp_step
  import jsvp_pkg::*;
(
  input  parse_state_t     state_i,
  input  logic [ByteW-1:0] byte_i,
  output parse_state_t     state_o,
  output logic             has_result_o,
  output result_t          result_o
);

  logic             is_end, is_space, is_digit, is_exp;
  logic             do_verdict, do_fail, do_emit, do_after;
  status_e          v_status, f_status;
  vtype_e           v_type, after_type;
  logic [ByteW-1:0] emit_byte;
  logic [ByteW-1:0] want;
  logic [2:0]       pos_next;
  parse_state_t     st;

  assign is_end   = (byte_i == 8'h00);
  assign is_space = (byte_i == 8'h20) || (byte_i == 8'h09) ||
                    (byte_i == 8'h0A) || (byte_i == 8'h0D);
  assign is_digit = (byte_i >= "0") && (byte_i <= "9");
  assign is_exp   = (byte_i == "e") || (byte_i == "E");
  assign want     = lit_char(state_i.lit_choice, state_i.lit_pos);
  assign pos_next = state_i.lit_pos + 3'd1;

  always_comb begin
    st         = state_i;
    do_verdict = 1'b0;
    do_fail    = 1'b0;
    do_emit    = 1'b0;
    do_after   = 1'b0;
    v_status   = ST_OK;
    v_type     = TY_NULL;
    f_status   = ST_OK;
    after_type = state_i.held_type;
    emit_byte  = 8'h00;

    case (state_i.phase)
      PH_LEAD: begin
        if (is_end) begin
          do_verdict = 1'b1;
          v_status   = ST_EXPECT;
        end else if (is_space) begin
          st.phase = PH_LEAD;
        end else if (byte_i == "n" || byte_i == "t" || byte_i == "f") begin
          st.lit_choice = (byte_i == "n") ? LIT_NULL :
                          (byte_i == "t") ? LIT_TRUE : LIT_FALSE;
          st.lit_pos    = 3'd1;
          st.phase      = PH_LIT;
        end else if (byte_i == "\"") begin
          st.phase = PH_STR;
        end else if (byte_i == "-") begin
          st.phase = PH_NSIGN;
        end else if (byte_i == "0") begin
          st.phase = PH_NZERO;
        end else if (is_digit) begin
          st.phase = PH_NINT;
        end else begin
          do_fail  = 1'b1;
          f_status = ST_INVALID;
        end
      end
      PH_LIT: begin
        if (want == 8'h00 || byte_i != want) begin
          do_fail  = 1'b1;
          f_status = ST_INVALID;
        end else begin
          st.lit_pos = pos_next;
          if (lit_char(state_i.lit_choice, pos_next) == 8'h00) begin
            st.held_type = lit_type(state_i.lit_choice);
            st.phase     = PH_TRAIL;
            st.lit_pos   = 3'd0;
          end
        end
      end
      PH_STR: begin
        if (byte_i == "\"") begin
          st.held_type = TY_STRING;
          st.phase     = PH_TRAIL;
        end else if (is_end) begin
          do_verdict = 1'b1;
          v_status   = ST_QUOTE;
        end else if (byte_i == "\\") begin
          st.phase = PH_ESC;
        end else if (byte_i < 8'h20) begin
          do_fail  = 1'b1;
          f_status = ST_CHAR;
        end else begin
          do_emit   = 1'b1;
          emit_byte = byte_i;
        end
      end
      PH_ESC: begin
        do_emit  = 1'b1;
        st.phase = PH_STR;
        case (byte_i)
          "\"":    emit_byte = "\"";
          "\\":    emit_byte = "\\";
          "/":     emit_byte = "/";
          "b":     emit_byte = 8'h08;
          "f":     emit_byte = 8'h0C;
          "n":     emit_byte = 8'h0A;
          "r":     emit_byte = 8'h0D;
          "t":     emit_byte = 8'h09;
          default: begin
            do_emit  = 1'b0;
            do_fail  = 1'b1;
            f_status = ST_ESCAPE;
            st.phase = PH_ESC;
          end
        endcase
      end
      PH_NSIGN: begin
        if (byte_i == "0") begin
          st.phase = PH_NZERO;
        end else if (is_digit) begin
          st.phase = PH_NINT;
        end else begin
          do_fail  = 1'b1;
          f_status = ST_INVALID;
        end
      end
      PH_NZERO, PH_NINT: begin
        if (state_i.phase == PH_NINT && is_digit) begin
          st.phase = PH_NINT;
        end else if (byte_i == ".") begin
          st.phase = PH_NDOT;
        end else if (is_exp) begin
          st.phase = PH_NEXP;
        end else begin
          do_after   = 1'b1;
          after_type = TY_NUMBER;
        end
      end
      PH_NDOT: begin
        if (is_digit) begin
          st.phase = PH_NFRAC;
        end else begin
          do_fail  = 1'b1;
          f_status = ST_INVALID;
        end
      end
      PH_NFRAC: begin
        if (is_digit) begin
          st.phase = PH_NFRAC;
        end else if (is_exp) begin
          st.phase = PH_NEXP;
        end else begin
          do_after   = 1'b1;
          after_type = TY_NUMBER;
        end
      end
      PH_NEXP: begin
        if (byte_i == "+" || byte_i == "-") begin
          st.phase = PH_NESIGN;
        end else if (is_digit) begin
          st.phase = PH_NEDIG;
        end else begin
          do_fail  = 1'b1;
          f_status = ST_INVALID;
        end
      end
      PH_NESIGN: begin
        if (is_digit) begin
          st.phase = PH_NEDIG;
        end else begin
          do_fail  = 1'b1;
          f_status = ST_INVALID;
        end
      end
      PH_NEDIG: begin
        if (!is_digit) begin
          do_after   = 1'b1;
          after_type = TY_NUMBER;
        end
      end
      PH_TRAIL: begin
        do_after = 1'b1;
      end
      default: begin
        // error phase, and unused codes behave the same
        if (is_end) begin
          do_verdict = 1'b1;
          v_status   = state_i.held_status;
        end else begin
          st.phase = PH_ERR;
        end
      end
    endcase

    // byte following a complete value
    if (do_after) begin
      st.held_type = after_type;
      if (is_end) begin
        do_verdict = 1'b1;
        v_status   = ST_OK;
        v_type     = after_type;
      end else if (is_space) begin
        st.phase = PH_TRAIL;
      end else begin
        do_fail  = 1'b1;
        f_status = ST_SINGULAR;
      end
    end

    if (do_fail) begin
      if (is_end) begin
        do_verdict = 1'b1;
        v_status   = f_status;
        v_type     = TY_NULL;
      end else begin
        st.held_status = f_status;
        st.held_type   = TY_NULL;
        st.phase       = PH_ERR;
      end
    end

    if (do_verdict) begin
      st = StateReset;
    end
  end

  assign state_o      = st;
  assign has_result_o = do_verdict || do_emit;

  always_comb begin
    result_o = '{kind: 1'b0, data: emit_byte, vtype: TY_NULL, status: ST_OK};
    if (do_verdict) begin
      result_o.kind   = 1'b1;
      result_o.data   = 8'h00;
      result_o.vtype  = (v_status == ST_OK) ? v_type : TY_NULL;
      result_o.status = v_status;
    end
  end

endmodule

FILE: sv/json_scalar_value_parser_unit.sv
// json scalar value parser: one text byte per request on the slave channel,
// a zero byte closes the text. leading and trailing whitespace is skipped,
// one literal, number or quoted string is checked in between.
// master channel: tuser low marks a decoded string byte (tdata[7:0]),
// tuser high with tlast marks the closing verdict (type tdata[10:8],
// status tdata[13:11]). after an error later bytes give no output but the
// closing verdict, and the consumer drops string bytes already seen for
// that text. a byte with a result goes from the input register through
// the parser state update into the output register.
// throughput: one byte per cycle unless the master side stalls, set by the
// single parser state update between the input and output registers.
// when the master side stalls, the output register holds its result and the
// input register takes one more byte; bytes that give no output still move
// on while the output waits.
// reset puts both registers empty and the parser at its leading whitespace
// state, ready for a new text.
module json_scalar_value_parser_unit
  import jsvp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ByteW-1:0]   s_axis_tdata_i,   // text_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TdataOW-1:0] m_axis_tdata_o,   // decoded_byte, value_type, parse_status
  output logic               m_axis_tuser_o,   // result_kind
  output logic               m_axis_tlast_o    // last_flag
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  parse_state_t     state_q, state_d;
  logic             has_result;
  result_t          result;
  logic             advance;

  jsvp_step u_step (
    .state_i      (state_q),
    .byte_i       (in_byte_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // a byte without output never waits for the master side
  assign advance = in_valid_q && (!has_result || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.status, out_q.vtype, out_q.data};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.kind;

`ifndef ASSERT_OFF
  a_verdict_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result && result.kind |=> state_q.phase == PH_LEAD)
    else $error("parser not back at leading whitespace after a verdict");

  a_byte_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result && !result.kind |->
      state_q.phase == PH_STR || state_q.phase == PH_ESC)
    else $error("string byte emitted outside a string");

  a_err_holds_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_ERR |-> state_q.held_status != ST_OK)
    else $error("error phase without an error status");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !(advance && has_result))
    else $error("pending result overwritten");
`endif

endmodule
